// File: rtl/bch_pkg.sv
// ----------------------------------------------------------------------------
// bch_pkg
// Shared widths, reset values and bit helpers for the BCH(31,21) corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package bch_pkg;

  localparam int WORD_BITS       = 32;
  localparam int POLY_BITS       = 11;
  localparam int IDX_BITS        = $clog2(WORD_BITS);
  localparam int CODE_LENGTH_DEF = 31;
  localparam int DATA_BITS_DEF   = 21;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [POLY_BITS-1:0] poly_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  localparam poly_t POLY_RESET = 11'h769;

  // isolate the lowest set bit
  function automatic word_t lowest_bit(word_t v);
    return v & (~v + word_t'(1));
  endfunction

  // index of a one-hot word (zero when empty)
  function automatic idx_t onehot_index(word_t oh);
    idx_t idx;
    idx = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (oh[k]) begin
        idx = idx | idx_t'(k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bch_ifs.sv
// ----------------------------------------------------------------------------
// bch_ifs
// Valid/ready channels of the corrector: received word, corrected word and
// generator write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bch_in_if;
  logic           valid;
  logic           ready;
  bch_pkg::word_t codeword_in;
  modport source (output valid, output codeword_in, input ready);
  modport sink   (input valid, input codeword_in, output ready);
endinterface

interface bch_out_if;
  logic           valid;
  logic           ready;
  bch_pkg::word_t codeword_out;
  modport source (output valid, output codeword_out, input ready);
  modport sink   (input valid, input codeword_out, output ready);
endinterface

interface bch_cfg_if;
  logic           valid;
  logic           ready;
  bch_pkg::poly_t generator_poly;
  modport source (output valid, output generator_poly, input ready);
  modport sink   (input valid, input generator_poly, output ready);
endinterface

`default_nettype wire

// File: rtl/bch_colgen.sv
// ----------------------------------------------------------------------------
// bch_colgen
// Holds the generator and builds the syndrome column of every word bit,
// one long-division step per cycle for all columns at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bch_colgen #(
  parameter int CODE_LENGTH = bch_pkg::CODE_LENGTH_DEF,
  parameter int DATA_BITS   = bch_pkg::DATA_BITS_DEF,
  parameter int REM_BITS    = bch_pkg::WORD_BITS - 1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  bch_cfg_if.sink                                  cfg,
  output logic                                     busy,
  output logic [bch_pkg::WORD_BITS-1:0][REM_BITS-1:0] cols
);
  import bch_pkg::*;

  localparam int STEP_W = $clog2(DATA_BITS);
  localparam logic [REM_BITS-1:0] TOP_MASK = REM_BITS'(1) << (CODE_LENGTH - 1);

  poly_t                              poly;
  logic [STEP_W-1:0]                  step;
  logic [REM_BITS-1:0]                mask_vec;
  logic [REM_BITS-1:0]                div_vec;
  logic [WORD_BITS-1:0][REM_BITS-1:0] cols_next;
  logic [WORD_BITS-1:0][REM_BITS-1:0] unit_cols;

  assign cfg.ready = 1'b1;

  always_comb begin
    mask_vec = TOP_MASK >> step;
    div_vec  = (REM_BITS'(poly) << (DATA_BITS - 1)) >> step;
    unit_cols[0] = '0;
    for (int i = 1; i < WORD_BITS; i++) begin
      unit_cols[i] = REM_BITS'(1) << (i - 1);
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      cols_next[i] = (|(cols[i] & mask_vec)) ? (cols[i] ^ div_vec) : cols[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= POLY_RESET;
      busy <= 1'b1;
      step <= '0;
      cols <= unit_cols;
    end else if (cfg.valid && cfg.ready) begin
      poly <= cfg.generator_poly;
      busy <= 1'b1;
      step <= '0;
      cols <= unit_cols;
    end else if (busy) begin
      cols <= cols_next;
      step <= step + STEP_W'(1);
      if (step == STEP_W'(DATA_BITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bch_locator.sv
// ----------------------------------------------------------------------------
// bch_locator
// Matches a syndrome against every single-bit column and every column pair,
// reducing each pair row to its first hit.
// ----------------------------------------------------------------------------
`default_nettype none

module bch_locator #(
  parameter int REM_BITS = bch_pkg::WORD_BITS - 1
) (
  input  logic [bch_pkg::WORD_BITS-1:0][REM_BITS-1:0]          cols,
  input  logic [REM_BITS-1:0]                                  syn,
  output bch_pkg::word_t                                       single_hit,
  output bch_pkg::word_t                                       row_hit,
  output logic [bch_pkg::WORD_BITS-1:0][bch_pkg::IDX_BITS-1:0] row_j
);
  import bch_pkg::*;

  word_t pair_m [WORD_BITS];

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      single_hit[i] = (cols[i] == syn);
      for (int j = 0; j < WORD_BITS; j++) begin
        pair_m[i][j] = (j > i) && ((cols[i] ^ cols[j]) == syn);
      end
      row_hit[i] = |pair_m[i];
      row_j[i]   = onehot_index(lowest_bit(pair_m[i]));
    end
  end

endmodule

`default_nettype wire

// File: rtl/bch_31_21_parity_corrector.sv
// ----------------------------------------------------------------------------
// bch_31_21_parity_corrector
// Paging codeword corrector: BCH(31,21) plus even parity, up to two bit flips.
// ----------------------------------------------------------------------------
// One codeword per cycle unless a rebuild runs or the output stalls; a result
// passes the input, syndrome, match and output registers after acceptance.
// The syndrome columns of all 32 bits are rebuilt after reset and after every
// generator write, one division step per cycle, and received.ready stays low
// while the rebuild runs. Each stage moves independently, so the pipeline
// keeps accepting while a result waits, until every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module bch_31_21_parity_corrector #(
  parameter int CODE_LENGTH = bch_pkg::CODE_LENGTH_DEF,
  parameter int DATA_BITS   = bch_pkg::DATA_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bch_in_if.sink     received,
  bch_out_if.source  corrected,
  bch_cfg_if.sink    cfg
);
  import bch_pkg::*;

  localparam int REM_BITS = (DATA_BITS + POLY_BITS - 1 > WORD_BITS - 1) ?
                            DATA_BITS + POLY_BITS - 1 : WORD_BITS - 1;

  logic                               busy;
  logic [WORD_BITS-1:0][REM_BITS-1:0] cols;
  logic [REM_BITS-1:0][WORD_BITS-1:0] cols_tr;

  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;
  logic in_fire;

  word_t                              w0, w1, w2;
  logic [REM_BITS-1:0]                syn_next, syn1;
  logic                               par1, par2, rzero2;
  word_t                              single_hit, row_hit;
  logic [WORD_BITS-1:0][IDX_BITS-1:0] row_j;
  word_t                              single2, rowhit2;
  logic [WORD_BITS-1:0][IDX_BITS-1:0] rowj2;
  word_t                              row_oh, flip, out_word;
  idx_t                               jsel;

  bch_colgen #(
    .CODE_LENGTH (CODE_LENGTH),
    .DATA_BITS   (DATA_BITS),
    .REM_BITS    (REM_BITS)
  ) u_colgen (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .busy (busy),
    .cols (cols)
  );

  bch_locator #(
    .REM_BITS (REM_BITS)
  ) u_locator (
    .cols       (cols),
    .syn        (syn1),
    .single_hit (single_hit),
    .row_hit    (row_hit),
    .row_j      (row_j)
  );

  assign rdy3 = !v3 || corrected.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;

  assign received.ready = rdy0 && !busy;
  assign in_fire        = received.valid && received.ready;

  assign corrected.valid        = v3;
  assign corrected.codeword_out = out_word;

  // syndrome as XOR of the columns of the set bits
  always_comb begin
    for (int b = 0; b < REM_BITS; b++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        cols_tr[b][i] = cols[i][b];
      end
      syn_next[b] = ^(w0 & cols_tr[b]);
    end
  end

  // odd parity: only single flips qualify; even with nonzero syndrome: pairs
  always_comb begin
    row_oh = lowest_bit(rowhit2);
    jsel   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (row_oh[i]) begin
        jsel = jsel | rowj2[i];
      end
    end
    if (par2) begin
      flip = lowest_bit(single2);
    end else if (rzero2 || (row_oh == '0)) begin
      flip = '0;
    end else begin
      flip = row_oh | (word_t'(1) << jsel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= in_fire;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      w0 <= received.codeword_in;
    end
    if (rdy1 && v0) begin
      w1   <= w0;
      syn1 <= syn_next;
      par1 <= ^w0;
    end
    if (rdy2 && v1) begin
      w2      <= w1;
      par2    <= par1;
      rzero2  <= (syn1 == '0);
      single2 <= single_hit;
      rowhit2 <= row_hit;
      rowj2   <= row_j;
    end
    if (rdy3 && v2) begin
      out_word <= w2 ^ flip;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> v0)
    else $error("accepted transaction not held in input stage");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> (busy && !received.ready))
    else $error("generator write did not start column rebuild");

  a_flip_limit: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3) |=> ($countones(corrected.codeword_out ^ $past(w2)) <= 2))
    else $error("correction flipped more than two bits");

endmodule

`default_nettype wire
